FILE: rtl/core/flm_pkg.sv
// Shared types and constants for the FIFO record lock manager.
// Field widths, status codes and default sizes; no dependencies.
`timescale 1ns / 1ps

package flm_pkg;

    localparam int TABLE_W    = 10;
    localparam int KEY_W      = 64;
    localparam int HANDLE_W   = 6;
    localparam int STATUS_W   = 3;

    localparam int RECORD_SLOTS_DEF = 16;
    localparam int HANDLE_SLOTS_DEF = 64;

    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_GRANTED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NEXT_GRANTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD          = 3'd5;

    typedef logic [TABLE_W-1:0]         table_t;
    typedef logic signed [KEY_W-1:0]    key_t;
    typedef logic [HANDLE_W-1:0]        ext_handle_t;
    typedef logic [STATUS_W-1:0]        status_t;

endpackage

FILE: rtl/core/flm_in_if.sv
// Request channel of the lock manager: valid/ready plus one request beat.
// Depends on flm_pkg for the field types.
`timescale 1ns / 1ps

interface flm_in_if
    import flm_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        action;
    table_t      table_number;
    key_t        record_key;
    ext_handle_t release_handle;

    modport source (output valid, output action, output table_number,
                    output record_key, output release_handle, input ready);
    modport sink   (input valid, input action, input table_number,
                    input record_key, input release_handle, output ready);
endinterface

FILE: rtl/core/flm_out_if.sv
// Response channel of the lock manager: valid/ready plus one response beat.
// Depends on flm_pkg for the field types.
`timescale 1ns / 1ps

interface flm_out_if
    import flm_pkg::*;
();
    logic        valid;
    logic        ready;
    status_t     status;
    ext_handle_t result_handle;

    modport source (output valid, output status, output result_handle, input ready);
    modport sink   (input valid, input status, input result_handle, output ready);
endinterface

FILE: rtl/core/flm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module flm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/flm_first_set.sv
// Lowest-index search over a flag vector, used for slot match and allocation.
// No dependencies.
`timescale 1ns / 1ps

module flm_first_set #(
    parameter int N = 16
) (
    input  logic [N-1:0]         flags,
    output logic                 found,
    output logic [$clog2(N)-1:0] index
);

    always_comb
    begin
        found = 1'b0;
        index = '0;
        // Scanning downward leaves the lowest set flag as the final pick.
        for (int i = N - 1; i >= 0; i--)
        begin
            if (flags[i])
            begin
                found = 1'b1;
                index = ($clog2(N))'(i);
            end
        end
    end

endmodule

FILE: rtl/core/fifo_record_lock_manager_core.sv
// Top level of the FIFO record lock manager: record slot table, handle pool
// and per-record waiter queues. Uses flm_pkg, flm_in_if, flm_out_if,
// flm_ram and flm_first_set.
//
//  channel    modport   beat contents
//  request    sink      action, table_number, record_key, release_handle
//  response   source    status, result_handle
//
// One request beat is taken per cycle unless the response stalls; a beat's
// response passes through the request register, then the response register.
// Each beat's state update completes in the cycle it leaves the request
// register, so the next beat sees it. The handle-to-slot map and successor
// indexes sit in RAMs read at acceptance, with a bypass for a write to the
// same handle in that cycle. Reset clears the slot valid, handle busy and
// successor valid flags; no clearing pass is needed. A stalled response holds
// the request stage.
`timescale 1ns / 1ps

module fifo_record_lock_manager_core
    import flm_pkg::*;
#(
    parameter int RECORD_SLOTS = RECORD_SLOTS_DEF,
    parameter int HANDLE_SLOTS = HANDLE_SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    flm_in_if.sink    request,
    flm_out_if.source response
);

    localparam int SW = $clog2(RECORD_SLOTS);
    localparam int HW = $clog2(HANDLE_SLOTS);

    typedef logic [SW-1:0] slot_idx_t;
    typedef logic [HW-1:0] handle_idx_t;

    // Handshake control.
    logic        s1_valid_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        s1_fire;
    logic        accept;

    // Request stage payload.
    logic        s1_action_reg;
    table_t      s1_table_reg;
    key_t        s1_key_reg;
    handle_idx_t s1_rel_reg;
    logic        s1_rel_in_range_reg;

    // Response register.
    status_t     out_status_reg;
    ext_handle_t out_handle_reg;
    status_t     res_status;
    ext_handle_t res_handle;

    // Record slot state.
    logic [RECORD_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    table_t      slot_table_reg [RECORD_SLOTS];
    table_t      slot_table_next [RECORD_SLOTS];
    key_t        slot_key_reg [RECORD_SLOTS];
    key_t        slot_key_next [RECORD_SLOTS];
    handle_idx_t slot_head_reg [RECORD_SLOTS];
    handle_idx_t slot_head_next [RECORD_SLOTS];
    handle_idx_t slot_tail_reg [RECORD_SLOTS];
    handle_idx_t slot_tail_next [RECORD_SLOTS];

    // Handle pool state; successor and slot indexes live in RAM.
    logic [HANDLE_SLOTS-1:0] busy_reg, busy_next;
    logic [HANDLE_SLOTS-1:0] succ_valid_reg, succ_valid_next;

    logic        hs_wr_en;
    handle_idx_t hs_wr_addr;
    slot_idx_t   hs_wr_data;
    slot_idx_t   hs_rd_data;
    logic        sx_wr_en;
    handle_idx_t sx_wr_addr;
    handle_idx_t sx_wr_data;
    handle_idx_t sx_rd_data;
    handle_idx_t rd_addr;

    logic        hs_fwd_reg;
    slot_idx_t   hs_fwd_data_reg;
    logic        sx_fwd_reg;
    handle_idx_t sx_fwd_data_reg;
    slot_idx_t   rel_slot;
    handle_idx_t rel_succ;

    // Searches.
    logic [RECORD_SLOTS-1:0] match_flags;
    logic        m_found, f_found, h_found;
    slot_idx_t   m_idx, f_idx;
    handle_idx_t h_idx;
    handle_idx_t tail_of_match;
    logic        rel_ok;

    assign out_free      = !out_valid_reg || response.ready;
    assign s1_fire       = s1_valid_reg && out_free;
    assign request.ready = !s1_valid_reg || s1_fire;
    assign accept        = request.valid && request.ready;
    assign rd_addr       = HW'(request.release_handle);

    assign response.valid         = out_valid_reg;
    assign response.status        = out_status_reg;
    assign response.result_handle = out_handle_reg;

    flm_ram #(.WIDTH(SW), .DEPTH(HANDLE_SLOTS)) u_handle_slot_ram (
        .clk     (clk),
        .wr_en   (hs_wr_en),
        .wr_addr (hs_wr_addr),
        .wr_data (hs_wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (hs_rd_data)
    );

    flm_ram #(.WIDTH(HW), .DEPTH(HANDLE_SLOTS)) u_successor_ram (
        .clk     (clk),
        .wr_en   (sx_wr_en),
        .wr_addr (sx_wr_addr),
        .wr_data (sx_wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (sx_rd_data)
    );

    always_comb
    begin
        for (int s = 0; s < RECORD_SLOTS; s++)
        begin
            match_flags[s] = slot_valid_reg[s] && (slot_table_reg[s] == s1_table_reg)
                             && (slot_key_reg[s] == s1_key_reg);
        end
    end

    flm_first_set #(.N(RECORD_SLOTS)) u_match_search (
        .flags (match_flags),
        .found (m_found),
        .index (m_idx)
    );

    flm_first_set #(.N(RECORD_SLOTS)) u_free_slot_search (
        .flags (~slot_valid_reg),
        .found (f_found),
        .index (f_idx)
    );

    flm_first_set #(.N(HANDLE_SLOTS)) u_free_handle_search (
        .flags (~busy_reg),
        .found (h_found),
        .index (h_idx)
    );

    assign tail_of_match = slot_tail_reg[m_idx];
    assign rel_slot = hs_fwd_reg ? hs_fwd_data_reg : hs_rd_data;
    assign rel_succ = sx_fwd_reg ? sx_fwd_data_reg : sx_rd_data;

    // A release is legal only for the busy handle that heads a live record.
    assign rel_ok = s1_rel_in_range_reg && busy_reg[s1_rel_reg]
                    && (32'(rel_slot) < RECORD_SLOTS)
                    && slot_valid_reg[rel_slot]
                    && (slot_head_reg[rel_slot] == s1_rel_reg);

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        slot_table_next = slot_table_reg;
        slot_key_next   = slot_key_reg;
        slot_head_next  = slot_head_reg;
        slot_tail_next  = slot_tail_reg;
        busy_next       = busy_reg;
        succ_valid_next = succ_valid_reg;
        hs_wr_en        = 1'b0;
        hs_wr_addr      = h_idx;
        hs_wr_data      = f_idx;
        sx_wr_en        = 1'b0;
        sx_wr_addr      = tail_of_match;
        sx_wr_data      = h_idx;
        res_status      = ST_FULL;
        res_handle      = '0;

        if (s1_action_reg == ACT_ACQUIRE)
        begin
            if (h_found && (m_found || f_found))
            begin
                busy_next[h_idx]       = 1'b1;
                succ_valid_next[h_idx] = 1'b0;
                hs_wr_en               = s1_fire;
                res_handle             = HANDLE_W'(h_idx);
                if (m_found)
                begin
                    // Join the back of the existing waiter queue.
                    hs_wr_data                     = m_idx;
                    succ_valid_next[tail_of_match] = 1'b1;
                    sx_wr_en                       = s1_fire;
                    slot_tail_next[m_idx]          = h_idx;
                    res_status                     = ST_QUEUED;
                end
                else
                begin
                    hs_wr_data             = f_idx;
                    slot_valid_next[f_idx] = 1'b1;
                    slot_table_next[f_idx] = s1_table_reg;
                    slot_key_next[f_idx]   = s1_key_reg;
                    slot_head_next[f_idx]  = h_idx;
                    slot_tail_next[f_idx]  = h_idx;
                    res_status             = ST_GRANTED;
                end
            end
        end
        else
        begin
            if (rel_ok)
            begin
                busy_next[s1_rel_reg] = 1'b0;
                if (succ_valid_reg[s1_rel_reg])
                begin
                    slot_head_next[rel_slot] = rel_succ;
                    res_status               = ST_NEXT_GRANTED;
                    res_handle               = HANDLE_W'(rel_succ);
                end
                else
                begin
                    slot_valid_next[rel_slot] = 1'b0;
                    res_status                = ST_FREED;
                end
            end
            else
            begin
                res_status = ST_BAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
            busy_reg       <= '0;
            succ_valid_reg <= '0;
        end
        else
        begin
            if (request.ready)
            begin
                s1_valid_reg <= request.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                slot_valid_reg <= slot_valid_next;
                busy_reg       <= busy_next;
                succ_valid_reg <= succ_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg       <= request.action;
            s1_table_reg        <= request.table_number;
            s1_key_reg          <= request.record_key;
            s1_rel_reg          <= rd_addr;
            s1_rel_in_range_reg <= (32'(request.release_handle) < HANDLE_SLOTS);
            // The RAM read sees old contents when the departing beat writes
            // the same handle, so catch that write here.
            hs_fwd_reg          <= hs_wr_en && (hs_wr_addr == rd_addr);
            hs_fwd_data_reg     <= hs_wr_data;
            sx_fwd_reg          <= sx_wr_en && (sx_wr_addr == rd_addr);
            sx_fwd_data_reg     <= sx_wr_data;
        end
        if (s1_fire)
        begin
            out_status_reg <= res_status;
            out_handle_reg <= res_handle;
            slot_table_reg <= slot_table_next;
            slot_key_reg   <= slot_key_next;
            slot_head_reg  <= slot_head_next;
            slot_tail_reg  <= slot_tail_next;
        end
    end

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for fifo_record_lock_manager_core: directed lock table rows, then
// random acquire/release traffic checked against an in-bench lock table model.
// Depends on flm_pkg, flm_in_if, flm_out_if and the core RTL.
`timescale 1ns / 1ps

module tb_top;
    import flm_pkg::*;

    localparam int NUM_RECORDS = RECORD_SLOTS_DEF;
    localparam int NUM_HANDLES = HANDLE_SLOTS_DEF;
    localparam int RANDOM_BEATS = 1800;
    localparam int NUM_HOT = 24;
    localparam int NUM_DIRECTED = 27;

    typedef struct packed {
        logic        act;
        table_t      tbl_id;
        key_t        key;
        ext_handle_t rel_handle;
        logic        typed;
        status_t     exp_status;
        ext_handle_t exp_handle;
    } lock_row_t;

    typedef struct packed {
        status_t     status;
        ext_handle_t handle;
    } lock_reply_t;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   mismatches;

    flm_in_if  request_if ();
    flm_out_if response_if ();

    fifo_record_lock_manager_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_if),
        .response (response_if)
    );

    // Lock table mirror: record slots with FIFO waiter chains through the handles.
    bit          rec_valid [NUM_RECORDS];
    table_t      rec_tbl   [NUM_RECORDS];
    key_t        rec_key   [NUM_RECORDS];
    ext_handle_t rec_head  [NUM_RECORDS];
    ext_handle_t rec_tail  [NUM_RECORDS];
    bit          hdl_busy  [NUM_HANDLES];
    bit          hdl_next_valid [NUM_HANDLES];
    ext_handle_t hdl_next  [NUM_HANDLES];
    logic [3:0]  hdl_record [NUM_HANDLES];

    table_t hot_tbl [NUM_HOT];
    key_t   hot_key [NUM_HOT];

    lock_reply_t lock_replies_q [$];
    lock_row_t   directed [NUM_DIRECTED];

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t lock reply mismatch: %s", $time, msg);
    endtask

    task automatic lock_table_step(input logic act, input table_t tbl_id, input key_t key,
                                   input ext_handle_t rel, output lock_reply_t reply);
        int match;
        int free_rec;
        int h;
        int s;
        match = -1;
        free_rec = -1;
        h = -1;
        reply.status = ST_BAD;
        reply.handle = '0;
        if (act == ACT_ACQUIRE)
        begin
            for (s = 0; s < NUM_RECORDS; s++)
            begin
                if (rec_valid[s])
                begin
                    if (match < 0 && rec_tbl[s] == tbl_id && rec_key[s] == key)
                        match = s;
                end
                else if (free_rec < 0)
                    free_rec = s;
            end
            for (s = NUM_HANDLES - 1; s >= 0; s--)
                if (!hdl_busy[s])
                    h = s;
            if (h < 0 || (match < 0 && free_rec < 0))
            begin
                reply.status = ST_FULL;
            end
            else
            begin
                hdl_busy[h] = 1'b1;
                hdl_next_valid[h] = 1'b0;
                reply.handle = ext_handle_t'(h);
                if (match >= 0)
                begin
                    hdl_record[h] = 4'(match);
                    hdl_next_valid[rec_tail[match]] = 1'b1;
                    hdl_next[rec_tail[match]] = ext_handle_t'(h);
                    rec_tail[match] = ext_handle_t'(h);
                    reply.status = ST_QUEUED;
                end
                else
                begin
                    rec_valid[free_rec] = 1'b1;
                    rec_tbl[free_rec] = tbl_id;
                    rec_key[free_rec] = key;
                    rec_head[free_rec] = ext_handle_t'(h);
                    rec_tail[free_rec] = ext_handle_t'(h);
                    hdl_record[h] = 4'(free_rec);
                    reply.status = ST_GRANTED;
                end
            end
        end
        else if (hdl_busy[rel])
        begin
            s = hdl_record[rel];
            if (rec_valid[s] && rec_head[s] == rel)
            begin
                hdl_busy[rel] = 1'b0;
                if (hdl_next_valid[rel])
                begin
                    rec_head[s] = hdl_next[rel];
                    reply.status = ST_NEXT_GRANTED;
                    reply.handle = hdl_next[rel];
                end
                else
                begin
                    rec_valid[s] = 1'b0;
                    reply.status = ST_FREED;
                end
            end
        end
    endtask

    // Mostly the current holder of some record, sometimes a waiter or any handle at all.
    function automatic ext_handle_t pick_release_handle(input bit noisy);
        ext_handle_t holders [$];
        ext_handle_t waiters [$];
        int roll;
        int s;
        roll = $urandom_range(0, 99);
        for (s = 0; s < NUM_RECORDS; s++)
            if (rec_valid[s])
                holders = {holders, rec_head[s]};
        for (s = 0; s < NUM_HANDLES; s++)
            if (hdl_busy[s] && rec_head[hdl_record[s]] != ext_handle_t'(s))
                waiters = {waiters, ext_handle_t'(s)};
        if (!noisy && roll < 70 && holders.size() > 0)
            return holders[$urandom_range(0, holders.size() - 1)];
        if (roll < 85 && waiters.size() > 0)
            return waiters[$urandom_range(0, waiters.size() - 1)];
        return ext_handle_t'($urandom);
    endfunction

    task automatic send_beat(input lock_row_t row);
        lock_reply_t predicted;
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 12)
        begin
            request_if.valid <= 1'b0;
            @(negedge clk);
        end
        request_if.valid          <= 1'b1;
        request_if.action         <= row.act;
        request_if.table_number   <= row.tbl_id;
        request_if.record_key     <= row.key;
        request_if.release_handle <= row.rel_handle;
        @(posedge clk);
        while (request_if.ready !== 1'b1)
            @(posedge clk);
        lock_table_step(row.act, row.tbl_id, row.key, row.rel_handle, predicted);
        if (row.typed)
        begin
            predicted.status = row.exp_status;
            predicted.handle = row.exp_handle;
        end
        lock_replies_q = {lock_replies_q, predicted};
    endtask

    initial
    begin
        response_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            response_if.ready <= quiet || ($urandom_range(0, 99) >= 12);
        end
    end

    always @(posedge clk)
    begin
        lock_reply_t want;
        if (rst_n && response_if.valid === 1'b1 && response_if.ready === 1'b1)
        begin
            if (lock_replies_q.size() == 0)
                report_mismatch($sformatf("unexpected beat status=%0d handle=%0d",
                                          response_if.status, response_if.result_handle));
            else
            begin
                want = lock_replies_q.pop_front();
                if (response_if.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              response_if.status, want.status));
                if (response_if.result_handle !== want.handle)
                    report_mismatch($sformatf("handle %0d, expected %0d",
                                              response_if.result_handle, want.handle));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[fifo_record_lock_manager_core] ERROR");
        $finish;
    end

    initial
    begin
        lock_row_t row;
        int mode;
        int acq_pct;
        int n;
        int i;

        rst_n = 1'b0;
        quiet = 1'b0;
        mismatches = 0;
        request_if.valid = 1'b0;
        request_if.action = ACT_ACQUIRE;
        request_if.table_number = '0;
        request_if.record_key = '0;
        request_if.release_handle = '0;
        for (i = 0; i < NUM_RECORDS; i++)
            rec_valid[i] = 1'b0;
        for (i = 0; i < NUM_HANDLES; i++)
        begin
            hdl_busy[i] = 1'b0;
            hdl_next_valid[i] = 1'b0;
        end
        for (i = 0; i < NUM_HOT; i++)
        begin
            hot_tbl[i] = table_t'($urandom_range(0, 3));
            hot_key[i] = key_t'($urandom_range(0, 5));
            if (i >= 12)
            begin
                hot_tbl[i] = table_t'($urandom);
                hot_key[i] = key_t'({$urandom, $urandom});
            end
        end

        // Holders, waiters and releases on a fresh table, then fill all record slots.
        directed = '{
            '{ACT_ACQUIRE, 10'd0,    64'sd0,                   6'd0,  1'b1, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd1023, 64'sh8000000000000000,    6'd0,  1'b1, ST_GRANTED, 6'd1},
            '{ACT_ACQUIRE, 10'd1023, 64'sh7FFFFFFFFFFFFFFF,    6'd63, 1'b1, ST_GRANTED, 6'd2},
            '{ACT_ACQUIRE, 10'd0,    64'sd0,                   6'd0,  1'b1, ST_QUEUED,  6'd3},
            '{ACT_ACQUIRE, 10'd0,    64'sd0,                   6'd63, 1'b1, ST_QUEUED,  6'd4},
            '{ACT_RELEASE, 10'd0,    64'sd0,                   6'd3,  1'b1, ST_BAD,     6'd0},
            '{ACT_RELEASE, 10'd0,    64'sd0,                   6'd63, 1'b1, ST_BAD,     6'd0},
            '{ACT_RELEASE, 10'd1023, -64'sd1,                  6'd0,  1'b1,
              ST_NEXT_GRANTED, 6'd3},
            '{ACT_RELEASE, 10'd0,    64'sd0,                   6'd3,  1'b1,
              ST_NEXT_GRANTED, 6'd4},
            '{ACT_RELEASE, 10'd0,    64'sd0,                   6'd4,  1'b1, ST_FREED,   6'd0},
            '{ACT_RELEASE, 10'd0,    64'sd0,                   6'd4,  1'b1, ST_BAD,     6'd0},
            '{ACT_ACQUIRE, 10'd0,    -64'sd1,                  6'd0,  1'b0, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd1,    64'sd1,                   6'd0,  1'b0, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd2,    64'sh5555555555555555,    6'd0,  1'b0, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd4,    64'shAAAAAAAAAAAAAAAA,    6'd0,  1'b0, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd8,    64'sh00000000FFFFFFFF,    6'd0,  1'b0, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd16,   64'shFFFFFFFF00000000,    6'd0,  1'b0, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd32,   64'sd2,                   6'd0,  1'b0, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd64,   64'sd3,                   6'd0,  1'b0, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd128,  64'sd4,                   6'd0,  1'b0, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd256,  64'sd5,                   6'd0,  1'b0, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd512,  64'sd6,                   6'd0,  1'b0, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd1023, 64'sd0,                   6'd0,  1'b0, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd0,    64'sh7FFFFFFFFFFFFFFF,    6'd0,  1'b0, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd341,  64'sh8000000000000000,    6'd0,  1'b0, ST_GRANTED, 6'd0},
            '{ACT_ACQUIRE, 10'd512,  64'sd7,                   6'd0,  1'b1, ST_FULL,    6'd0},
            '{ACT_ACQUIRE, 10'd1023, 64'sh8000000000000000,    6'd0,  1'b0, ST_QUEUED,  6'd0}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < NUM_DIRECTED; i++)
            send_beat(directed[i]);

        // Traffic comes in phases: balanced, acquire-heavy on a few hot records
        // (drives the handle pool to full), release-heavy, and noisy.
        mode = 0;
        acq_pct = 50;
        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 150 == 0)
            begin
                mode = $urandom_range(0, 3);
                acq_pct = (mode == 1) ? 80 : (mode == 2) ? 25 : 50;
            end
            quiet = (n >= 700 && n < 1000);
            row.typed = 1'b0;
            row.exp_status = ST_GRANTED;
            row.exp_handle = '0;
            row.rel_handle = ext_handle_t'($urandom);
            row.tbl_id = table_t'($urandom);
            row.key = key_t'({$urandom, $urandom});
            if ($urandom_range(0, 99) < acq_pct)
            begin
                row.act = ACT_ACQUIRE;
                if (mode != 3 && $urandom_range(0, 9) != 0)
                begin
                    i = (mode == 1 && $urandom_range(0, 9) < 7) ?
                        $urandom_range(0, 3) : $urandom_range(0, NUM_HOT - 1);
                    row.tbl_id = hot_tbl[i];
                    row.key = hot_key[i];
                end
            end
            else
            begin
                row.act = ACT_RELEASE;
                row.rel_handle = pick_release_handle(mode == 3);
            end
            send_beat(row);
        end
        quiet = 1'b0;

        @(negedge clk);
        request_if.valid <= 1'b0;
        while (lock_replies_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("[fifo_record_lock_manager_core] OK");
        else
            $display("[fifo_record_lock_manager_core] ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/flm_pkg.sv
rtl/core/flm_in_if.sv
rtl/core/flm_out_if.sv
rtl/core/flm_ram.sv
rtl/core/flm_first_set.sv
rtl/core/fifo_record_lock_manager_core.sv
verif/tb_top.sv
